FILE: rtl/stli_pkg.sv
// Shared constants and codes for the sorted-table linear interpolator.
package stli_pkg;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int KIND_WIDTH      = 2;
    localparam int STATUS_WIDTH    = 3;
    localparam int POS_WIDTH       = 8;

    localparam logic [KIND_WIDTH-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_EVAL   = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_INVERT = 2'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_CLEAR  = 2'd3;

    localparam logic [STATUS_WIDTH-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_EMPTY  = 3'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_SINGLE = 3'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_RANGE  = 3'd3;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL   = 3'd4;
    localparam logic [STATUS_WIDTH-1:0] ST_ZWIDTH = 3'd5;

endpackage

FILE: rtl/stli_if.sv
// Request and response channel interfaces of the interpolator.
interface stli_req_if import stli_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [KIND_WIDTH-1:0]         kind;
    logic signed [VALUE_WIDTH-1:0] coord_x;
    logic signed [VALUE_WIDTH-1:0] value_y;

    modport source (output valid, kind, coord_x, value_y, input ready);
    modport sink   (input valid, kind, coord_x, value_y, output ready);
endinterface

interface stli_rsp_if import stli_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] result;
    logic [STATUS_WIDTH-1:0]       status;
    logic [POS_WIDTH-1:0]          position;
    logic [POS_WIDTH-1:0]          entry_count;

    modport source (output valid, result, status, position, entry_count, input ready);
    modport sink   (input valid, result, status, position, entry_count, output ready);
endinterface

FILE: rtl/stli_mem.sv
// Point table memory: one write port, one registered read port.
module stli_mem import stli_pkg::*; #(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int DW    = 2 * VALUE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wen,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end
endmodule

FILE: rtl/stli_lerp.sv
// Iterative interpolation unit: shift-add multiply, restoring divide, saturate.
module stli_lerp import stli_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [VALUE_WIDTH-1:0] i_a1,
    input  logic signed [VALUE_WIDTH-1:0] i_b1,
    input  logic signed [VALUE_WIDTH-1:0] i_a2,
    input  logic signed [VALUE_WIDTH-1:0] i_b2,
    input  logic signed [VALUE_WIDTH-1:0] i_q,
    output logic                          o_done,
    output logic signed [VALUE_WIDTH-1:0] o_res
);
    localparam int VW   = VALUE_WIDTH;
    localparam int DW1  = VW + 1;
    localparam int PW   = 2 * DW1;
    localparam int CNTW = $clog2(PW + 1);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_MUL  = 2'd1;
    localparam logic [1:0] L_DIV  = 2'd2;
    localparam logic [1:0] L_FIN  = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [DW1-1:0]  r_db, n_db, r_da, n_da, r_rem, n_rem;
    logic [PW-1:0]   r_prod, n_prod;
    logic [VW-1:0]   r_b1, n_b1, r_res, n_res;
    logic            r_neg, n_neg, r_done, n_done;

    logic [DW1-1:0] d_b, d_q, d_a, room;
    logic [DW1:0]   sum, rem_sh;
    logic           ge;

    always_comb begin
        d_b = {i_b2[VW-1], i_b2} - {i_b1[VW-1], i_b1};
        d_q = {i_q[VW-1], i_q} - {i_a1[VW-1], i_a1};
        d_a = {i_a2[VW-1], i_a2} - {i_a1[VW-1], i_a1};
        sum    = {1'b0, r_prod[PW-1:DW1]} + (r_prod[0] ? {1'b0, r_db} : '0);
        rem_sh = {r_rem, r_prod[PW-1]};
        ge     = rem_sh >= {1'b0, r_da};
        if (r_neg) begin
            room = {r_b1[VW-1], r_b1} + {2'b00, {(VW-1){1'b1}}} + DW1'(1);
        end else begin
            room = {2'b00, {(VW-1){1'b1}}} - {r_b1[VW-1], r_b1};
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_db    = r_db;
        n_da    = r_da;
        n_rem   = r_rem;
        n_prod  = r_prod;
        n_b1    = r_b1;
        n_neg   = r_neg;
        n_res   = r_res;
        n_done  = 1'b0;
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_db    = d_b[DW1-1] ? -d_b : d_b;
                    n_da    = d_a[DW1-1] ? -d_a : d_a;
                    n_prod  = {{DW1{1'b0}}, (d_q[DW1-1] ? -d_q : d_q)};
                    n_neg   = d_b[DW1-1] ^ d_q[DW1-1] ^ d_a[DW1-1];
                    n_b1    = i_b1;
                    n_cnt   = '0;
                    n_state = L_MUL;
                end
            end
            L_MUL: begin
                n_prod = {sum, r_prod[DW1-1:1]};
                n_cnt  = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(DW1 - 1)) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_state = L_DIV;
                end
            end
            L_DIV: begin
                n_rem  = ge ? DW1'(rem_sh - {1'b0, r_da}) : rem_sh[DW1-1:0];
                n_prod = {r_prod[PW-2:0], ge};
                n_cnt  = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(PW - 1)) begin
                    n_state = L_FIN;
                end
            end
            L_FIN: begin
                if (r_prod == '0) begin
                    n_res = r_b1;
                end else if (r_prod > PW'(room)) begin
                    n_res = r_neg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
                end else if (r_neg) begin
                    n_res = r_b1 - r_prod[VW-1:0];
                end else begin
                    n_res = r_b1 + r_prod[VW-1:0];
                end
                n_done  = 1'b1;
                n_state = L_IDLE;
            end
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt  <= n_cnt;
        r_db   <= n_db;
        r_da   <= n_da;
        r_rem  <= n_rem;
        r_prod <= n_prod;
        r_b1   <= n_b1;
        r_neg  <= n_neg;
        r_res  <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

FILE: rtl/sorted_table_linear_interpolator_core.sv
// Sorted (x,y) point table with insert, evaluate, invert and clear in Q16.16.
// One request at a time, one response per request. Evaluate and invert scan the
// table from index 0 at one entry per cycle (the single memory read port), then
// run the interpolation unit (a one-entry table is compared directly); insert scans
// to the insertion point and moves each later entry up with a read and a write;
// clear resets the entry count.
// A finished response is held in an output register while the next request runs.
module sorted_table_linear_interpolator_core import stli_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    stli_req_if.sink   i_req,
    stli_rsp_if.source o_rsp
);
    localparam int VW = VALUE_WIDTH;
    localparam int EW = 2 * VW;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_ONE  = 4'd2;
    localparam logic [3:0] S_ONEW = 4'd3;
    localparam logic [3:0] S_F1   = 4'd4;
    localparam logic [3:0] S_F1W  = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_LERP = 4'd7;
    localparam logic [3:0] S_SHRD = 4'd8;
    localparam logic [3:0] S_SHWR = 4'd9;
    localparam logic [3:0] S_INS  = 4'd10;
    localparam logic [3:0] S_EMIT = 4'd11;

    logic [3:0]              r_state, n_state;
    logic [KIND_WIDTH-1:0]   r_kind, n_kind;
    logic signed [VW-1:0]    r_x, n_x, r_y, n_y, r_res, n_res;
    logic [CW-1:0]           r_count, n_count, r_idx, n_idx, r_pos, n_pos;
    logic                    r_dv, n_dv, r_lstart, n_lstart;
    logic [EW-1:0]           r_prev, n_prev, r_cur, n_cur;
    logic [STATUS_WIDTH-1:0] r_status, n_status;

    logic                    r_ov, n_ov;
    logic signed [VW-1:0]    r_ores, n_ores;
    logic [STATUS_WIDTH-1:0] r_ostat, n_ostat;
    logic [POS_WIDTH-1:0]    r_opos, n_opos, r_ocnt, n_ocnt;

    logic          mem_wen;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, rd_data;

    logic signed [VW-1:0] d_x, d_y, p_x, p_y, c_x, c_y;
    logic signed [VW-1:0] l_a1, l_b1, l_a2, l_b2, l_q, l_res;
    logic                 l_done, is_eval, match, last;
    logic [CW-1:0]        k, k_prev;
    logic [CW+POS_WIDTH-1:0] pos_ext, cnt_ext;

    stli_mem #(.DEPTH(TABLE_DEPTH), .DW(EW)) u_mem (
        .i_clk   (i_clk),
        .i_wen   (mem_wen),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    stli_lerp #(.VALUE_WIDTH(VW)) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_lstart),
        .i_a1    (l_a1),
        .i_b1    (l_b1),
        .i_a2    (l_a2),
        .i_b2    (l_b2),
        .i_q     (l_q),
        .o_done  (l_done),
        .o_res   (l_res)
    );

    assign d_x = rd_data[EW-1:VW];
    assign d_y = rd_data[VW-1:0];
    assign p_x = r_prev[EW-1:VW];
    assign p_y = r_prev[VW-1:0];
    assign c_x = r_cur[EW-1:VW];
    assign c_y = r_cur[VW-1:0];
    assign is_eval = (r_kind == KIND_EVAL);

    assign l_a1 = is_eval ? c_x : c_y;
    assign l_b1 = is_eval ? c_y : c_x;
    assign l_a2 = is_eval ? p_x : p_y;
    assign l_b2 = is_eval ? p_y : p_x;
    assign l_q  = is_eval ? r_x : r_y;

    assign k      = r_idx - CW'(1);
    assign k_prev = r_idx - CW'(1);
    assign last   = (k == r_count - CW'(1));

    always_comb begin
        match = 1'b0;
        case (r_kind) inside
            KIND_INSERT, KIND_EVAL: match = (d_x >= r_x);
            default: match = (k != '0) &&
                             (((p_y < r_y) && (r_y <= d_y)) || ((d_y < r_y) && (r_y <= p_y)));
        endcase
    end

    always_comb begin
        mem_raddr = r_idx[AW-1:0];
        case (r_state)
            S_SHRD:  mem_raddr = k_prev[AW-1:0];
            S_F1:    mem_raddr = AW'(1);
            S_ONE:   mem_raddr = '0;
            default: mem_raddr = r_idx[AW-1:0];
        endcase
    end

    assign pos_ext = {{POS_WIDTH{1'b0}}, r_pos};
    assign cnt_ext = {{POS_WIDTH{1'b0}}, r_count};

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_x      = r_x;
        n_y      = r_y;
        n_res    = r_res;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_dv     = r_dv;
        n_prev   = r_prev;
        n_cur    = r_cur;
        n_status = r_status;
        n_lstart = 1'b0;
        n_ov     = r_ov && !o_rsp.ready;
        n_ores   = r_ores;
        n_ostat  = r_ostat;
        n_opos   = r_opos;
        n_ocnt   = r_ocnt;
        mem_wen   = 1'b0;
        mem_waddr = r_pos[AW-1:0];
        mem_wdata = {r_x, r_y};
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_kind   = i_req.kind;
                    n_x      = i_req.coord_x;
                    n_y      = i_req.value_y;
                    n_res    = '0;
                    n_status = ST_OK;
                    n_pos    = '0;
                    n_idx    = '0;
                    n_dv     = 1'b0;
                    n_state  = S_SCAN;
                    case (i_req.kind)
                        KIND_CLEAR: begin
                            n_count = '0;
                            n_state = S_EMIT;
                        end
                        KIND_INSERT: begin
                            if (r_count == CW'(TABLE_DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_EMIT;
                            end else if (r_count == '0) begin
                                n_state = S_INS;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_EMIT;
                            end else if (r_count == CW'(1)) begin
                                n_state = S_ONE;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx < r_count) begin
                    n_idx = r_idx + CW'(1);
                    n_dv  = 1'b1;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    n_prev = rd_data;
                    n_cur  = rd_data;
                    case (r_kind)
                        KIND_INSERT: begin
                            if (match) begin
                                n_pos   = k;
                                n_idx   = r_count;
                                n_state = S_SHRD;
                            end else if (last) begin
                                n_pos   = r_count;
                                n_state = S_INS;
                            end
                        end
                        KIND_EVAL: begin
                            if (match || last) begin
                                n_pos   = k;
                                n_prev  = r_prev;
                                n_state = (k == '0) ? S_F1 : S_CHK;
                            end
                        end
                        default: begin
                            if (match) begin
                                n_pos   = k;
                                n_prev  = r_prev;
                                n_state = S_CHK;
                            end else if (last) begin
                                n_status = ST_RANGE;
                                n_state  = S_EMIT;
                            end
                        end
                    endcase
                end
            end
            S_F1: n_state = S_F1W;
            S_F1W: begin
                n_prev  = rd_data;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (is_eval && (c_x == p_x)) begin
                    n_status = ST_ZWIDTH;
                    n_state  = S_EMIT;
                end else begin
                    n_lstart = 1'b1;
                    n_state  = S_LERP;
                end
            end
            S_LERP: begin
                if (l_done) begin
                    n_res   = l_res;
                    n_state = S_EMIT;
                end
            end
            S_ONE: n_state = S_ONEW;
            S_ONEW: begin
                if (is_eval ? (d_x == r_x) : (d_y == r_y)) begin
                    n_res = is_eval ? d_y : d_x;
                end else begin
                    n_status = ST_SINGLE;
                end
                n_state = S_EMIT;
            end
            S_SHRD: n_state = (r_idx > r_pos) ? S_SHWR : S_INS;
            S_SHWR: begin
                mem_wen   = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = rd_data;
                n_idx     = r_idx - CW'(1);
                n_state   = S_SHRD;
            end
            S_INS: begin
                mem_wen = 1'b1;
                n_count = r_count + CW'(1);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov    = 1'b1;
                    n_ores  = r_res;
                    n_ostat = r_status;
                    n_opos  = pos_ext[POS_WIDTH-1:0];
                    n_ocnt  = cnt_ext[POS_WIDTH-1:0];
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_dv     <= 1'b0;
            r_lstart <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_dv     <= n_dv;
            r_lstart <= n_lstart;
            r_ov     <= n_ov;
        end
        r_kind   <= n_kind;
        r_x      <= n_x;
        r_y      <= n_y;
        r_res    <= n_res;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_prev   <= n_prev;
        r_cur    <= n_cur;
        r_status <= n_status;
        r_ores   <= n_ores;
        r_ostat  <= n_ostat;
        r_opos   <= n_opos;
        r_ocnt   <= n_ocnt;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ov;
    assign o_rsp.result      = r_ores;
    assign o_rsp.status      = r_ostat;
    assign o_rsp.position    = r_opos;
    assign o_rsp.entry_count = r_ocnt;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("point count beyond table depth");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && (r_ostat != ST_OK) |-> (r_ores == '0))
        else $error("error response with non-zero result");

    a_lerp_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        l_done |-> (r_state == S_LERP))
        else $error("interpolation finished outside its wait state");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wen |-> (r_kind == KIND_INSERT))
        else $error("table written by a non-insert request");
endmodule
